### hw/rtl/sha256bc_pkg.sv
// ----------------------------------------------------------------------------
// sha256bc_pkg
// types, initial values and round constants of the sha-256 compression unit
// ----------------------------------------------------------------------------
`default_nettype none

package sha256bc_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;   // index 0 is word a / h0

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROUND,
      S_ADD,
      S_DRAIN
   } state_type;

   // schedule window taps that feed the round unit
   typedef struct packed {
      word_type w0;
      word_type w1;
      word_type w9;
      word_type w14;
   } taps_type;

   localparam int          CSR_ADDR_WIDTH = 3;
   localparam logic        CSR_IDX_VARIANT = 1'b0;
   localparam logic [5:0]  ROUND_LAST = 6'd63;
   localparam logic [3:0]  WORD_LAST = 4'd15;
   localparam logic [2:0]  INDEX_LAST = 3'd7;

   localparam hash_type IV_256 = {
      32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
      32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
   };

   localparam hash_type IV_224 = {
      32'hBEFA4FA4, 32'h64F98FA7, 32'h68581511, 32'hFFC00B31,
      32'hF70E5939, 32'h3070DD17, 32'h367CD507, 32'hC1059ED8
   };

   function automatic word_type round_k(input logic [5:0] t);
      word_type k;
      unique case (t)
         6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
         6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
         6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
         6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
         6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
         6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
         6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
         6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
         6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
         6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
         6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
         6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
         6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
         6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
         6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
         6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
         6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
         6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
         6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
         6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
         6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
         6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
         6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
         6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
         6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
         6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
         6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
         6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
         6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
         6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/sha256_block_compression_unit.sv
// ----------------------------------------------------------------------------
// sha256_block_compression_unit
// sha-256 / sha-224 block compression with a streaming word input and
// a streaming digest output
// ----------------------------------------------------------------------------
// Message words arrive as beats, sixteen to a block. Words one to fifteen of
// a block are taken while the unit is idle. The sixteenth word starts
// the shared round unit, which does one round per cycle through all the
// rounds of the block and then the chaining add. No word is taken until
// both are done, nor, when that word carries tlast, until the digest buffer
// is loaded as well. When the sixteenth word carries tlast the eight digest
// words are copied into an output buffer and sent as eight beats, word 0
// first, while new words are already taken; a further digest waits only if
// the buffer still holds the previous one.
// The variant register (address 0) picks the initial values loaded on a
// beat that has start set in tuser: 0 sha-256, 1 sha-224.
`default_nettype none

module sha256_block_compression_unit
   import sha256bc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // message word beats
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // [31:0] msg_word
   input  logic [0:0]                req_tuser,   // [0] start_message
   input  logic                      req_tlast,   // end_message
   // digest word beats
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // [31:0] digest_word
   output logic [2:0]                rsp_tuser,   // [2:0] word_index
   output logic                      rsp_tlast,   // last
   // configuration
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   // control state
   state_type  state_ff, state_in;
   logic [3:0] word_cnt_ff, word_cnt_in;
   logic [5:0] round_ff, round_in;
   logic       end_ff, end_in;
   logic       variant_ff, variant_in;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_idx_ff, out_idx_in;
   hash_type   cv_ff, cv_in;

   // payload
   hash_type        work_ff, work_in;
   word_type [15:0] sched_ff, sched_in;
   hash_type        out_buf_ff, out_buf_in;

   logic     req_beat, rsp_beat, csr_write;
   logic [3:0] word_pos;
   hash_type round_state;
   word_type w_new;
   taps_type taps;

   assign req_beat  = req_tvalid && req_tready;
   assign rsp_beat  = rsp_tvalid && rsp_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // a start beat always becomes word 0 of a fresh block
   assign word_pos = req_tuser[0] ? 4'd0 : word_cnt_ff;

   // ------------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_VARIANT) ? {31'd0, variant_ff} : 32'd0;

   always_comb begin
      variant_in = variant_ff;
      if (csr_write && csr_paddr[2] == CSR_IDX_VARIANT) begin
         variant_in = csr_pwdata[0];
      end
   end

   // ------------------------------------------------------------------------
   // shared round unit
   // ------------------------------------------------------------------------
   assign taps = '{w0: sched_ff[0], w1: sched_ff[1], w9: sched_ff[9], w14: sched_ff[14]};

   sha256bc_round u_round (
      .state_i (work_ff),
      .k_i     (round_k(round_ff)),
      .taps_i  (taps),
      .state_o (round_state),
      .w_new_o (w_new)
   );

   // ------------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat && word_pos == WORD_LAST) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            if (round_ff == ROUND_LAST) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            state_in = end_ff ? S_DRAIN : S_IDLE;
         end
         S_DRAIN: begin
            if (!out_valid_ff) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer: outputs and datapath control
   // ------------------------------------------------------------------------
   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      word_cnt_in  = word_cnt_ff;
      round_in     = round_ff;
      end_in       = end_ff;
      cv_in        = cv_ff;
      work_in      = work_ff;
      sched_in     = sched_ff;
      out_buf_in   = out_buf_ff;
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;

      // digest beats drain word 0 first, buffer shifts down
      if (rsp_beat) begin
         out_buf_in = {32'd0, out_buf_ff[7:1]};
         out_idx_in = out_idx_ff + 3'd1;
         if (out_idx_ff == INDEX_LAST) begin
            out_valid_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (req_tuser[0]) begin
                  cv_in = variant_ff ? IV_224 : IV_256;
               end
               sched_in    = {req_tdata, sched_ff[15:1]};
               word_cnt_in = word_pos + 4'd1;
               if (word_pos == WORD_LAST) begin
                  work_in  = cv_ff;
                  end_in   = req_tlast;
                  round_in = 6'd0;
               end
            end
         end
         S_ROUND: begin
            work_in  = round_state;
            sched_in = {w_new, sched_ff[15:1]};
            round_in = round_ff + 6'd1;
         end
         S_ADD: begin
            for (int i = 0; i < 8; i++) begin
               cv_in[i] = cv_ff[i] + work_ff[i];
            end
            work_in = cv_in;
         end
         S_DRAIN: begin
            if (!out_valid_ff) begin
               out_buf_in   = cv_ff;
               out_valid_in = 1'b1;
               out_idx_in   = 3'd0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_buf_ff[0];
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = (out_idx_ff == INDEX_LAST);

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         word_cnt_ff  <= 4'd0;
         round_ff     <= 6'd0;
         end_ff       <= 1'b0;
         variant_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= 3'd0;
         cv_ff        <= IV_256;
      end else begin
         state_ff     <= state_in;
         word_cnt_ff  <= word_cnt_in;
         round_ff     <= round_in;
         end_ff       <= end_in;
         variant_ff   <= variant_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
         cv_ff        <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      sched_ff   <= sched_in;
      out_buf_ff <= out_buf_in;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   a_round_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == ROUND_LAST) |=> state_ff == S_ADD)
      else $error("round sequence did not end in the chaining add");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("digest beat follows the last word without a reload");

   a_drain_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && !out_valid_ff) |=> (rsp_tvalid && rsp_tuser == 3'd0))
      else $error("digest reload did not start at word 0");

   a_no_input_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND || state_ff == S_ADD) |-> !req_tready)
      else $error("input taken while the round unit is busy");
`endif

endmodule

`default_nettype wire

### hw/rtl/sha256bc_round.sv
// ----------------------------------------------------------------------------
// sha256bc_round
// one sha-256 round and one message schedule expansion step
// ----------------------------------------------------------------------------
`default_nettype none

module sha256bc_round
   import sha256bc_pkg::*;
(
   input  hash_type state_i,
   input  word_type k_i,
   input  taps_type taps_i,
   output hash_type state_o,
   output word_type w_new_o
);

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   word_type a, b, c, d, e, f, g, h;
   word_type big0, big1, ch, maj, t1, t2, sig0, sig1;

   always_comb begin
      {h, g, f, e, d, c, b, a} = state_i;
      big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      ch = (e & f) ^ (~e & g);
      maj = (a & b) ^ (a & c) ^ (b & c);
      t1 = h + big1 + ch + k_i + taps_i.w0;
      t2 = big0 + maj;
      state_o = {g, f, e, d + t1, c, b, a, t1 + t2};
   end

   // w[t+16] from the current window
   always_comb begin
      sig0 = rotr(taps_i.w1, 7) ^ rotr(taps_i.w1, 18) ^ (taps_i.w1 >> 3);
      sig1 = rotr(taps_i.w14, 17) ^ rotr(taps_i.w14, 19) ^ (taps_i.w14 >> 10);
      w_new_o = sig1 + taps_i.w9 + sig0 + taps_i.w0;
   end

endmodule

`default_nettype wire

### bench/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// predicts and checks the digest beats of the sha-256 compression unit
// ----------------------------------------------------------------------------
// Watches the message, digest and register channels. Every accepted message
// word goes through a behavioral copy of the unit; each digest beat is
// compared with the oldest predicted word. Register reads are checked
// against the tracked variant.

module sha256_digest_checker
   import sha256bc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [31:0]               req_tdata,   // [31:0] msg_word
   input  logic [0:0]                req_tuser,   // [0] start_message
   input  logic                      req_tlast,   // end_message
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [31:0]               rsp_tdata,   // [31:0] digest_word
   input  logic [2:0]                rsp_tuser,   // [2:0] word_index
   input  logic                      rsp_tlast,   // last
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   input  logic [31:0]               csr_prdata,
   input  logic                      csr_pready,
   output int unsigned               failures,
   output int unsigned               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_WIDTH-1:0] VARIANT_ADDR = {CSR_IDX_VARIANT, 2'b00};

   typedef struct packed {
      word_type   word;
      logic [2:0] index;
      logic       last;
   } digest_beat_type;

   word_type k_table [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   digest_beat_type digest_q [$];
   digest_beat_type oldest;
   hash_type        chain;
   word_type        sched [16];
   logic [3:0]      fill;
   logic            iv_select;
   int unsigned     error_count;

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // 64 rounds over the rolling schedule, then fold into the chaining value
   function automatic void compress_block();
      hash_type r;
      word_type wa, wb, t1, t2, e, a;
      r = chain;
      for (int t = 0; t < 64; t++) begin
         if (t >= 16) begin
            wa = sched[(t - 2) & 15];
            wb = sched[(t - 15) & 15];
            sched[t & 15] = (rotr(wa, 17) ^ rotr(wa, 19) ^ (wa >> 10)) + sched[(t - 7) & 15]
                          + (rotr(wb, 7) ^ rotr(wb, 18) ^ (wb >> 3)) + sched[t & 15];
         end
         e = r[4];
         a = r[0];
         t1 = r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & r[5]) ^ (~e & r[6]))
            + k_table[t] + sched[t & 15];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & r[1]) ^ (a & r[2]) ^ (r[1] & r[2]));
         r = {r[6:0], word_type'(t1 + t2)};
         r[4] = r[4] + t1;
      end
      for (int i = 0; i < 8; i++)
         chain[i] = chain[i] + r[i];
   endfunction

   function automatic void absorb_word(input word_type data, input logic head,
                                       input logic tail);
      if (head) begin
         chain = iv_select ? IV_224 : IV_256;
         fill = '0;
      end
      sched[fill] = data;
      if (fill != WORD_LAST) begin
         fill = fill + 4'd1;
      end else begin
         fill = '0;
         compress_block();
         if (tail)
            for (int k = 0; k < 8; k++)
               digest_q.push_back('{word: chain[k], index: 3'(k), last: (k == 7)});
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         chain = IV_256;
         fill = '0;
         iv_select = 1'b0;
         error_count = 0;
         digest_q.delete();
         foreach (sched[i]) sched[i] = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == VARIANT_ADDR) iv_select = csr_pwdata[0];
            end else if (csr_prdata !== {31'b0, iv_select}) begin
               $display("%0t: variant read expected %h, got %h", $time,
                        {31'b0, iv_select}, csr_prdata);
               error_count++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (digest_q.size() == 0) begin
               $display("%0t: digest beat expected none, got %h/%0d/%b", $time,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               oldest = digest_q.pop_front();
               if (rsp_tdata !== oldest.word || rsp_tuser !== oldest.index ||
                   rsp_tlast !== oldest.last) begin
                  $display("%0t: digest beat expected %h/%0d/%b, got %h/%0d/%b", $time,
                           oldest.word, oldest.index, oldest.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_word(req_tdata, req_tuser[0], req_tlast);
      end
      failures <= error_count;
      outstanding <= digest_q.size();
   end

endmodule

### bench/tb_sha256_block_compression_unit.sv
// ----------------------------------------------------------------------------
// tb_sha256_block_compression_unit
// stimulus and verdict for the sha-256 block compression unit
// ----------------------------------------------------------------------------
// Drives message words, flow control on the digest side and the
// variant register; a separate checker predicts every digest beat. A short
// directed opening and a long receiver hold-off are followed by randomized
// traffic in phases with different idling.

module tb_sha256_block_compression_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [sha256bc_pkg::CSR_ADDR_WIDTH-1:0] VARIANT_ADDR =
      {sha256bc_pkg::CSR_IDX_VARIANT, 2'b00};
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 1000;  // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 5000;  // well above the hold-off
   localparam int PHASE_ITEMS    = 75;

   logic                                      clock = 1'b0;
   logic                                      reset = 1'b1;
   logic                                      req_tvalid = 1'b0;
   logic                                      req_tready;
   logic [31:0]                               req_tdata = '0;   // [31:0] msg_word
   logic [0:0]                                req_tuser = '0;   // [0] start_message
   logic                                      req_tlast = 1'b0; // end_message
   logic                                      rsp_tvalid;
   logic                                      rsp_tready = 1'b0;
   logic [31:0]                               rsp_tdata;        // [31:0] digest_word
   logic [2:0]                                rsp_tuser;        // [2:0] word_index
   logic                                      rsp_tlast;        // last
   logic                                      csr_psel = 1'b0;
   logic                                      csr_penable = 1'b0;
   logic                                      csr_pwrite = 1'b0;
   logic [sha256bc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr = '0;
   logic [31:0]                               csr_pwdata = '0;
   logic [31:0]                               csr_prdata;
   logic                                      csr_pready;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned items_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned quiet_cycles = 0;

   // idling per phase: sender gap and receiver stall chances in percent
   int unsigned send_idle_tab [4] = '{0, 61, 0, 27};
   int unsigned rsp_stall_tab [4] = '{0, 0, 61, 27};
   logic        variant_tab [4]   = '{1'b0, 1'b1, 1'b0, 1'b1};

   sha256_block_compression_unit dut (.*);

   sha256_digest_checker checker_i (.*);

   initial forever #10 clock = ~clock;

   // digest side flow control; a hold-off request freezes tready for a
   // long stretch counted here, so the unit backs up into its input
   initial begin
      int unsigned hold_seen;
      int unsigned hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // watchdog: cycles with no beat moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_sha256_block_compression_unit failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // mostly random words, now and then all zeros or all ones
   function automatic logic [31:0] pick_word();
      int unsigned roll;
      roll = $urandom_range(15);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   // one message word beat, after a random gap
   task automatic offer_word(input logic [31:0] data, input logic head, input logic tail);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= head;
      req_tlast <= tail;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // well-formed message; without head it continues the current chain
   task automatic send_message(input int blocks, input logic head);
      for (int b = 0; b < blocks; b++)
         for (int i = 0; i < 16; i++)
            offer_word(pick_word(), head && b == 0 && i == 0, b == blocks - 1 && i == 15);
   endtask

   // message abandoned mid-block, with stray end marks that must be ignored
   task automatic send_fragment();
      int n;
      n = $urandom_range(15, 1);
      for (int i = 0; i < n; i++)
         offer_word(pick_word(), i == 0, $urandom_range(1));
   endtask

   // random flags on every word
   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++)
         offer_word(pick_word(), $urandom_range(3) == 0, $urandom_range(1));
   endtask

   task automatic send_traffic(input int unsigned quota);
      int unsigned goal;
      int unsigned pick;
      goal = items_sent + quota;
      while (items_sent < goal) begin
         pick = $urandom_range(9);
         if (pick < 5)       send_message(1, 1'b1);
         else if (pick < 7)  send_message($urandom_range(3, 2), 1'b1);
         else if (pick == 7) send_message(1, 1'b0);
         else if (pick == 8) send_fragment();
         else                send_noise($urandom_range(8, 1));
      end
   endtask

   // stop sending, let every digest drain and a last silent block finish
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write the variant register, then read it back for the checker
   task automatic program_variant(input logic value);
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= VARIANT_ADDR;
      csr_pwdata <= {31'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no start after reset: the reset chaining value is used; an end mark
      // on word five is ignored, the one on word sixteen emits the digest
      for (int i = 0; i < 16; i++)
         offer_word((i % 4 == 0) ? 32'h0000_0000 : (i % 4 == 1) ? 32'hFFFF_FFFF : $urandom,
                    1'b0, i == 4 || i == 15);
      // two-word fragment, then a message whose start lands mid-block
      offer_word($urandom, 1'b1, 1'b0);
      offer_word(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_message(1, 1'b1);

      // back-pressure: the receiver holds off while whole messages keep
      // coming, so the output buffer fills and the input stalls
      program_variant(1'b1);
      hold_requests++;
      repeat (4) send_message(1, 1'b1);

      for (int p = 0; p < 4; p++) begin
         program_variant(variant_tab[p]);
         send_idle_pct = send_idle_tab[p];
         rsp_stall_pct = rsp_stall_tab[p];
         send_traffic(PHASE_ITEMS);
      end

      wait_drained();
      if (failures == 0 && outstanding == 0)
         $display("tb_sha256_block_compression_unit passed");
      else
         $display("tb_sha256_block_compression_unit failed");
      $finish;
   end

endmodule
